// ===== sv/tkss_pkg.sv =====
// Shared constants, types and exponent tables for the top-k softmax block.
package tkss_pkg;

  localparam int MAX_K        = 8;
  localparam int MAX_ELEMENTS = 256;
  localparam int KW           = $clog2(MAX_K + 1);
  localparam int RW           = $clog2(MAX_K);
  localparam int PW           = $clog2(MAX_ELEMENTS + 1);
  localparam int SUMW         = 20;
  localparam int QDEPTH       = 2;

  localparam logic [KW-1:0] TOP_K_RESET = KW'(2);

  typedef struct packed {
    logic [MAX_K-1:0][15:0] value;
    logic [MAX_K-1:0][7:0]  index;
    logic [MAX_K-1:0]       filled;
    logic [KW-1:0]          k;
  } frame_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_DLOAD,
    B_DIV,
    B_OUT
  } back_state_t;

  function automatic logic [16:0] exp_int(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] exp_hi(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd61565;
      4'd2:    r = 17'd57835;
      4'd3:    r = 17'd54331;
      4'd4:    r = 17'd51039;
      4'd5:    r = 17'd47947;
      4'd6:    r = 17'd45042;
      4'd7:    r = 17'd42313;
      4'd8:    r = 17'd39750;
      4'd9:    r = 17'd37341;
      4'd10:   r = 17'd35079;
      4'd11:   r = 17'd32954;
      4'd12:   r = 17'd30957;
      4'd13:   r = 17'd29081;
      4'd14:   r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] exp_lo(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd65280;
      4'd2:    r = 17'd65026;
      4'd3:    r = 17'd64772;
      4'd4:    r = 17'd64520;
      4'd5:    r = 17'd64268;
      4'd6:    r = 17'd64018;
      4'd7:    r = 17'd63768;
      4'd8:    r = 17'd63520;
      4'd9:    r = 17'd63272;
      4'd10:   r = 17'd63025;
      4'd11:   r = 17'd62780;
      4'd12:   r = 17'd62535;
      4'd13:   r = 17'd62291;
      4'd14:   r = 17'd62048;
      default: r = 17'd61806;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/top_k_select_softmax.sv =====
// Top level: configuration register, front end, frame queue and back end.
//
// Usage: logits stream in on s_tvalid/s_tready/s_tdata, one signed Q8.8 value
// per beat, with s_tlast on the final beat of a frame. Items are numbered from
// zero within a frame; the 8 largest of the first 256 are kept in a sorted
// slot list, updated in the beat's own cycle, so one beat per cycle is taken
// inside a frame. After the frame's last beat, top_k result beats (top_k 0
// counts as 1, above 8 as 8) leave on m_tvalid/m_tready, in rank order, with
// m_tlast on the final one. Per frame the back end picks up the frame, works
// out the exponent of each ranked slot in B_MUL1 and B_MUL2 (two table
// multiplies), then for each result runs a load state, a one-bit-per-cycle
// divider and an output state that holds until the result is taken.
// A two-frame queue lets the next frame stream in meanwhile; s_tready drops
// only when that queue is full. When the receiver stalls, the result beat is
// held in its output register. top_k is written over the APB port at address 0
// and resets to 2. Reset (synchronous, active high) clears the slot list, the
// queue and the back end.
module top_k_select_softmax (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] logit
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] element_index, [8] index_valid, [24:9] weight
  output logic        m_tlast
);
  import tkss_pkg::*;

  logic [KW-1:0] top_k;
  logic          q_full, q_push, q_pop, q_valid;
  frame_t        q_in, q_head;
  logic [7:0]    element_index;
  logic          index_valid;
  logic [15:0]   weight;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {{(32 - KW){1'b0}}, top_k} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_k <= TOP_K_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      top_k <= pwdata[KW-1:0];
    end
  end

  tkss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .logit     (s_tdata),
    .frame_end (s_tlast),
    .top_k     (top_k),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  tkss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tkss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .element_index (element_index),
    .index_valid   (index_valid),
    .weight        (weight),
    .last          (m_tlast)
  );

  assign m_tdata = {7'd0, weight, index_valid, element_index};

endmodule

// ===== sv/tkss_front.sv =====
// Front end: accepts logits and keeps the sorted slot list of one frame.
module tkss_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          logit,
  input  logic                 frame_end,
  input  logic [tkss_pkg::KW-1:0] top_k,
  input  logic                 q_full,
  output logic                 q_push,
  output tkss_pkg::frame_t     q_data
);
  import tkss_pkg::*;

  logic [MAX_K-1:0][15:0] value, value_next;
  logic [MAX_K-1:0][7:0]  index, index_next;
  logic [MAX_K-1:0]       filled, filled_next;
  logic [MAX_K-1:0]       take;
  logic [PW-1:0]          position_count;
  logic                   accept;
  logic                   rank;
  logic [KW-1:0]          k_eff;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign rank     = position_count < PW'(MAX_ELEMENTS);

  // The take vector is a thermometer: filled slots form a sorted prefix.
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      take[i] = !filled[i] || ($signed(logit) > $signed(value[i]));
    end
    for (int i = 0; i < MAX_K; i++) begin
      value_next[i]  = value[i];
      index_next[i]  = index[i];
      filled_next[i] = filled[i];
      if (rank && take[i]) begin
        if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
          value_next[i]  = value[(i > 0) ? i - 1 : 0];
          index_next[i]  = index[(i > 0) ? i - 1 : 0];
          filled_next[i] = filled[(i > 0) ? i - 1 : 0];
        end else begin
          value_next[i]  = logit;
          index_next[i]  = position_count[7:0];
          filled_next[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (top_k == '0) begin
      k_eff = KW'(1);
    end else if (top_k > KW'(MAX_K)) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = top_k;
    end
  end

  assign q_push        = accept && frame_end;
  assign q_data.value  = value_next;
  assign q_data.index  = index_next;
  assign q_data.filled = filled_next;
  assign q_data.k      = k_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      filled         <= '0;
      value          <= '0;
      index          <= '0;
      position_count <= '0;
    end else if (accept) begin
      if (frame_end) begin
        filled         <= '0;
        value          <= '0;
        index          <= '0;
        position_count <= '0;
      end else begin
        filled <= filled_next;
        value  <= value_next;
        index  <= index_next;
        if (rank) begin
          position_count <= position_count + PW'(1);
        end
      end
    end
  end

endmodule

// ===== sv/tkss_queue.sv =====
// Short queue of finished frame lists between the front and back ends.
module tkss_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tkss_pkg::frame_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output tkss_pkg::frame_t head
);
  import tkss_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  frame_t                 entry [QDEPTH];
  logic [AW-1:0]          wr_ptr, rd_ptr;
  logic [$clog2(QDEPTH+1)-1:0] count;

  assign full      = count == ($bits(count))'(QDEPTH);
  assign not_empty = count != '0;
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(QDEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == AW'(QDEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push && !full, pop && not_empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/tkss_back.sv =====
// Back end: exponents, sum, one restoring division per result, output register.
module tkss_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  tkss_pkg::frame_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       element_index,
  output logic             index_valid,
  output logic [15:0]      weight,
  output logic             last
);
  import tkss_pkg::*;

  back_state_t       state, state_next;
  logic [RW-1:0]     r;
  logic [16:0]       x1;
  logic [16:0]       ex [MAX_K];
  logic [SUMW-1:0]   sum;
  logic [31:0]       num;
  logic [SUMW-1:0]   rem;
  logic [15:0]       quo;
  logic [4:0]        cnt;
  logic [15:0]       d;
  logic              r_last;
  logic [SUMW:0]     rem_sh;
  logic              q_bit;
  logic [SUMW-1:0]   rem_step;
  logic [33:0]       prod1, prod2;
  logic              out_take;

  assign d        = q_head.value[0] - q_head.value[r];
  assign r_last   = {1'b0, r} == q_head.k - KW'(1);
  assign rem_sh   = {rem, num[31]};
  assign q_bit    = rem_sh >= {1'b0, sum};
  assign rem_step = q_bit ? SUMW'(rem_sh - {1'b0, sum}) : rem_sh[SUMW-1:0];
  assign prod1    = exp_int(d[11:8]) * exp_hi(d[7:4]);
  assign prod2    = x1 * exp_lo(d[3:0]);
  assign out_take = out_valid && out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (q_valid) state_next = B_MUL1;
      B_MUL1:  state_next = B_MUL2;
      B_MUL2:  state_next = r_last ? B_DLOAD : B_MUL1;
      B_DLOAD: state_next = B_DIV;
      B_DIV:   if (cnt == '0) state_next = B_OUT;
      B_OUT:   if (out_ready) state_next = r_last ? B_IDLE : B_DLOAD;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid = 1'b0;
    q_pop     = 1'b0;
    unique case (state)
      B_OUT: begin
        out_valid = 1'b1;
        q_pop     = out_ready && r_last;
      end
      default: begin
        out_valid = 1'b0;
        q_pop     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r <= '0;
    end else if (state == B_IDLE) begin
      r <= '0;
    end else if (state == B_MUL2) begin
      r <= r_last ? '0 : r + RW'(1);
    end else if (out_take && !r_last) begin
      r <= r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        sum <= '0;
      end
      B_MUL1: begin
        x1 <= prod1[32:16];
      end
      B_MUL2: begin
        if (q_head.filled[r] && q_head.filled[0] && d[15:12] == 4'd0) begin
          ex[r] <= prod2[32:16];
          sum   <= sum + SUMW'(prod2[32:16]);
        end else begin
          ex[r] <= '0;
        end
      end
      B_DLOAD: begin
        // ex * 65535 without a multiplier.
        num <= {ex[r][15:0], 16'd0} - {15'd0, ex[r]};
        rem <= '0;
        quo <= '0;
        cnt <= 5'd31;
      end
      B_DIV: begin
        num <= {num[30:0], 1'b0};
        rem <= rem_step;
        quo <= {quo[14:0], q_bit};
        cnt <= cnt - 5'd1;
        if (cnt == '0) begin
          element_index <= q_head.filled[r] ? q_head.index[r] : 8'd0;
          index_valid   <= q_head.filled[r];
          weight        <= (q_head.filled[r] && sum != '0) ? {quo[14:0], q_bit} : 16'd0;
          last          <= r_last;
        end
      end
      default: begin
        x1 <= x1;
      end
    endcase
  end

  a_out_has_frame: assert property (@(posedge clk) disable iff (rst)
    state == B_OUT |-> q_valid)
    else $error("result shown without a frame at the queue head");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !index_valid |-> weight == 16'd0 && element_index == 8'd0)
    else $error("empty slot carries a weight or index");

  a_rank_in_range: assert property (@(posedge clk) disable iff (rst)
    state != B_IDLE |-> {1'b0, r} < q_head.k)
    else $error("rank counter passed top_k");

  a_pop_after_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> last)
    else $error("frame left the queue before its last result");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the top-k select softmax block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_TOP_K = 3'd0;
  localparam int NUM_SLOTS = 8;
  localparam int POS_LIMIT = 256;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [7:0]  element_index;
    logic        index_valid;
    logic [15:0] weight;
    logic        last;
  } ranked_beat_t;

  class gating_scoreboard;
    logic signed [15:0] rank_value [NUM_SLOTS];
    logic [7:0]         rank_index [NUM_SLOTS];
    logic               rank_used [NUM_SLOTS];
    int unsigned        position;
    logic [3:0]         k_setting;
    ranked_beat_t       pending_beats [$];
    int                 error_count;

    int unsigned int_tab [16] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                  22, 8, 3, 1, 0, 0, 0, 0};
    int unsigned hi_tab [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                 42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                 27319, 25664};
    int unsigned lo_tab [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
                                 63768, 63520, 63272, 63025, 62780, 62535, 62291,
                                 62048, 61806};

    function new();
      k_setting = 4'd2;
      error_count = 0;
      clear_ranking();
    endfunction

    function void clear_ranking();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        rank_value[i] = '0;
        rank_index[i] = '0;
        rank_used[i] = 1'b0;
      end
      position = 0;
    endfunction

    function longint unsigned neg_exp(logic [15:0] d);
      longint unsigned x;
      if (d >= 16'd4096) return 0;
      x = (longint'(int_tab[d[11:8]]) * hi_tab[d[7:4]]) >> 16;
      x = (x * lo_tab[d[3:0]]) >> 16;
      return x;
    endfunction

    function void rank_logit(logic signed [15:0] v, logic [7:0] idx);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!rank_used[i] || v > rank_value[i]) begin
          for (int j = NUM_SLOTS - 1; j > i; j--) begin
            rank_value[j] = rank_value[j-1];
            rank_index[j] = rank_index[j-1];
            rank_used[j] = rank_used[j-1];
          end
          rank_value[i] = v;
          rank_index[i] = idx;
          rank_used[i] = 1'b1;
          return;
        end
      end
    endfunction

    function void note_input(logic signed [15:0] v, logic frame_end);
      int k;
      longint unsigned ex [NUM_SLOTS];
      longint unsigned total;
      logic [15:0] d;
      ranked_beat_t b;
      if (position < POS_LIMIT) begin
        rank_logit(v, position[7:0]);
        position++;
      end
      if (!frame_end) return;
      k = (k_setting == 0) ? 1 : (k_setting > NUM_SLOTS ? NUM_SLOTS : k_setting);
      total = 0;
      for (int r = 0; r < k; r++) begin
        ex[r] = 0;
        if (rank_used[r] && rank_used[0]) begin
          d = rank_value[0] - rank_value[r];
          ex[r] = neg_exp(d);
        end
        total += ex[r];
      end
      for (int r = 0; r < k; r++) begin
        b.element_index = rank_used[r] ? rank_index[r] : 8'd0;
        b.index_valid = rank_used[r];
        b.weight = (rank_used[r] && total != 0) ? 16'((ex[r] * 65535) / total) : 16'd0;
        b.last = (r == k - 1);
        pending_beats.push_back(b);
      end
      clear_ranking();
    endfunction

    function void check_result(logic [31:0] data, logic last);
      ranked_beat_t e;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat data=%h last=%b", $time, data, last);
        error_count++;
        return;
      end
      e = pending_beats.pop_front();
      if (data[7:0] !== e.element_index) begin
        $display("%0t: element_index expected %0d actual %0d", $time, e.element_index,
                 data[7:0]);
        error_count++;
      end
      if (data[8] !== e.index_valid) begin
        $display("%0t: index_valid expected %b actual %b", $time, e.index_valid, data[8]);
        error_count++;
      end
      if (data[24:9] !== e.weight) begin
        $display("%0t: weight expected %0d actual %0d", $time, e.weight, data[24:9]);
        error_count++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, last);
        error_count++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // [15:0] logit
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // [7:0] element_index, [8] index_valid, [24:9] weight
  logic        m_tlast;

  gating_scoreboard sb = new();
  bit quiet = 1'b0;      // no idling on either side while set
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int items_sent = 0;

  always #10 clk = ~clk;

  top_k_select_softmax DUT (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = 700;
      hold_request = 1'b0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  task automatic send_logit(input logic [15:0] v, input logic frame_end);
    while (!quiet && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tlast <= frame_end;
    do @(posedge clk); while (!s_tready);
    sb.note_input(v, frame_end);
    items_sent++;
  endtask

  task automatic send_frame(input int len, input int mode);
    logic [15:0] base;
    logic [15:0] v;
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = 16'($urandom);
        1: v = base + 16'($urandom_range(0, 5000));    // close values
        2: v = base + 16'($urandom_range(0, 3) * 256); // ties
        default: v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      endcase
      send_logit(v, i == len - 1);
    end
  endtask

  task automatic write_top_k(input logic [3:0] k);
    // Wait for the block to drain before changing the register.
    s_tvalid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_TOP_K;
    pwdata <= 32'(k);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.k_setting = k;
  endtask

  initial begin
    logic [3:0] k_values [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd3};
    int len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset value of top_k, then short frames and extremes.
    send_logit(16'h7FFF, 1'b1);            // one element with k = 2, empty slot
    send_logit(16'h8000, 1'b0);
    send_logit(16'h7FFF, 1'b1);
    write_top_k(4'd8);
    send_logit(16'h0000, 1'b0);            // ties keep arrival order
    send_logit(16'h0000, 1'b0);
    send_logit(16'h0100, 1'b0);
    send_logit(16'h0000, 1'b0);
    send_logit(16'hF000, 1'b0);            // difference of 16.0 or more
    send_logit(16'h8000, 1'b1);
    write_top_k(4'd0);                     // acts as one
    send_logit(16'h1234, 1'b0);
    send_logit(16'h1235, 1'b1);
    write_top_k(4'd15);                    // acts as eight
    for (int i = 0; i < 10; i++) send_logit(16'(i * 255), i == 9);
    write_top_k(4'd1);
    send_logit(16'h8000, 1'b1);

    // Random frames across several settings.
    for (int phase = 0; phase < 6; phase++) begin
      write_top_k(k_values[phase]);
      quiet = (phase == 2);
      if (phase == 3) hold_request = 1'b1;  // sender keeps offering frames meanwhile
      for (int f = 0; f < 5; f++) send_frame($urandom_range(1, 10), $urandom_range(3));
    end
    quiet = 1'b0;

    // Overlong frame, past the ranking limit, then a mixed tail.
    write_top_k(4'd8);
    send_frame(270, 1);
    while (items_sent < 450) begin
      len = $urandom_range(1, 12);
      send_frame(len, $urandom_range(3));
    end
    s_tvalid <= 1'b0;

    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_beats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/tkss_pkg.sv
sv/tkss_front.sv
sv/tkss_queue.sv
sv/tkss_back.sv
sv/top_k_select_softmax.sv
bench/tb_top.sv
